// ----- hw/rtl/ts_pkg.sv -----
// Shared types and widths for the triangle setup block.
// No dependencies; imported by the front, queue, back and top level.
package ts_pkg;

	localparam int CoordW = 16;
	localparam int EdgeW  = 17;
	localparam int CrossW = 34;
	localparam int DotW   = 35;
	localparam int LenW   = 70;
	localparam int QDepth = 4;
	localparam int QIdxW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	localparam logic [1:0] SlotEdge0  = 2'd0;
	localparam logic [1:0] SlotEdge1  = 2'd1;
	localparam logic [1:0] SlotNormal = 2'd2;
	localparam logic [1:0] SlotCentre = 2'd3;

	typedef logic signed [EdgeW-1:0]  edge_t;
	typedef logic signed [CrossW-1:0] cross_t;
	typedef logic signed [DotW-1:0]   dot_t;

	typedef struct packed {
		edge_t  [2:0] e0;
		edge_t  [2:0] e1;
		cross_t [2:0] cr;
		dot_t         d00;
		dot_t         d11;
		dot_t         d01;
		edge_t  [2:0] cen;
	} entry_t;

	typedef struct packed {
		logic             full;
		logic             empty;
		logic [QCntW-1:0] count;
	} q_status_t;

endpackage

// ----- hw/rtl/ts_front.sv -----
// Front end: accepts vertex beats, forms edges, dot and cross products, centroid.
// Depends on ts_pkg; feeds ts_queue.
module ts_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [ts_pkg::CoordW-1:0] ax, ay, az, bx, by_coord, bz, cx, cy, cz,
	input  ts_pkg::q_status_t               qstat,
	output logic                            push,
	output ts_pkg::entry_t                  push_data
);
	import ts_pkg::*;

	logic         v_s1, v_s2;
	edge_t  [2:0] e0_s1, e1_s1;
	logic signed [EdgeW:0] sum_s1 [3];
	entry_t       ent_s2;
	logic         take;
	logic [QCntW+1:0] inflight;

	assign inflight = (QCntW+2)'(qstat.count) + (QCntW+2)'(v_s1) + (QCntW+2)'(v_s2);
	assign busy = (inflight >= (QCntW+2)'(QDepth));
	assign take = start && !busy;

	logic signed [CoordW-1:0] va [3], vb [3], vc [3];
	assign va = '{ax, ay, az};
	assign vb = '{bx, by_coord, bz};
	assign vc = '{cx, cy, cz};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			e0_s1[2-i]  <= EdgeW'(vb[i]) - EdgeW'(va[i]);
			e1_s1[2-i]  <= EdgeW'(vc[i]) - EdgeW'(va[i]);
			sum_s1[i]   <= (EdgeW+1)'(va[i]) + (EdgeW+1)'(vb[i]) + (EdgeW+1)'(vc[i]);
		end
	end

	logic signed [2*EdgeW-1:0] p00 [3], p11 [3], p01 [3];
	logic signed [2*EdgeW-1:0] xa [3], xb [3];
	logic [EdgeW-1:0]          smag [3];
	logic [EdgeW+15:0]         sprod [3];
	logic [EdgeW-2:0]          squo [3];
	entry_t                    ent_c;

	always_comb begin
		ent_c = '0;
		for (int i = 0; i < 3; i++) begin
			p00[i] = e0_s1[i] * e0_s1[i];
			p11[i] = e1_s1[i] * e1_s1[i];
			p01[i] = e0_s1[i] * e1_s1[i];
			smag[i] = sum_s1[i][EdgeW] ? EdgeW'(-sum_s1[i]) : EdgeW'(sum_s1[i]);
			sprod[i] = (EdgeW+16)'(smag[i]) * (EdgeW+16)'(16'd43691);
			squo[i] = sprod[i][EdgeW+15:17];
			ent_c.cen[2-i] = sum_s1[i][EdgeW] ? -EdgeW'(squo[i]) : EdgeW'(squo[i]);
		end
		// index 2 is x, 1 is y, 0 is z
		xa[0] = e0_s1[1] * e1_s1[0];  xb[0] = e0_s1[0] * e1_s1[1];
		xa[1] = e0_s1[0] * e1_s1[2];  xb[1] = e0_s1[2] * e1_s1[0];
		xa[2] = e0_s1[2] * e1_s1[1];  xb[2] = e0_s1[1] * e1_s1[2];
		for (int i = 0; i < 3; i++) begin
			ent_c.cr[2-i] = CrossW'(xa[i]) - CrossW'(xb[i]);
		end
		ent_c.e0  = e0_s1;
		ent_c.e1  = e1_s1;
		ent_c.d00 = DotW'(p00[0]) + DotW'(p00[1]) + DotW'(p00[2]);
		ent_c.d11 = DotW'(p11[0]) + DotW'(p11[1]) + DotW'(p11[2]);
		ent_c.d01 = DotW'(p01[0]) + DotW'(p01[1]) + DotW'(p01[2]);
	end

	always_ff @(posedge clk) begin
		ent_s2 <= ent_c;
	end

	assign push      = v_s2;
	assign push_data = ent_s2;

endmodule

// ----- hw/rtl/ts_queue.sv -----
// Short queue between front and back end.
// Depends on ts_pkg.
module ts_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ts_pkg::entry_t    push_data,
	input  logic              pop,
	output ts_pkg::entry_t    head,
	output ts_pkg::q_status_t qstat
);
	import ts_pkg::*;

	entry_t           mem_q [QDepth];
	logic [QIdxW-1:0] wr_q, rd_q;
	logic [QCntW-1:0] cnt_q;
	logic             do_pop;

	assign do_pop = pop && (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + QCntW'(push) - QCntW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	assign head        = mem_q[rd_q];
	assign qstat.count = cnt_q;
	assign qstat.empty = (cnt_q == '0);
	assign qstat.full  = (cnt_q == QCntW'(QDepth));

endmodule

// ----- hw/rtl/ts_back.sv -----
// Back end: squared length, unit normal, reciprocal by iteration, then four result beats.
// Depends on ts_pkg; takes entries from ts_queue.
module ts_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ts_pkg::q_status_t        qstat,
	input  ts_pkg::entry_t           head,
	output logic                     pop,
	output logic                     strobe,
	output logic [1:0]               slot,
	output logic                     last_result,
	output logic signed [16:0]       vec_x,
	output logic signed [16:0]       vec_y,
	output logic signed [16:0]       vec_z,
	output logic signed [34:0]       scalar_value,
	output logic signed [7:0]        recip_exponent,
	output logic                     degenerate
);
	import ts_pkg::*;

	localparam int NW = 100;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SQ, ST_CHK, ST_SCAN, ST_NORM, ST_DIV, ST_EMIT
	} state_t;

	state_t             state_q;
	entry_t             ent_q;
	logic [1:0]         idx_q;
	logic [65:0]        sq_q [3];
	logic [LenW-1:0]    len_q, sh_q;
	logic [6:0]         k_q, bit_q, top_q;
	logic signed [7:0]  ex_q;
	logic               deg_q;
	logic [3:0]         b_q;
	logic [NW-1:0]      p_q, qv_q;
	logic [14:0]        qn_q;
	edge_t  [2:0]       nm_q;
	logic [LenW:0]      r_q;
	logic [31:0]        mant_q;
	logic [1:0]         slot_q;

	logic [32:0]   m_c;
	logic [65:0]   sqr_c;
	logic [NW-1:0] cand_c, rhs_c, lw_c;
	logic [14:0]   qt_c;
	logic          ge_c;
	logic [LenW:0] rn_c;
	logic          pow2_c;

	always_comb begin
		m_c    = ent_q.cr[2-idx_q][CrossW-1] ? 33'(-ent_q.cr[2-idx_q])
		                                      : 33'(ent_q.cr[2-idx_q]);
		sqr_c  = 66'(m_c) * 66'(m_c);
		lw_c   = NW'(len_q);
		cand_c = p_q + (qv_q << (5'(b_q) + 5'd1)) + (lw_c << (5'(b_q) << 1));
		rhs_c  = {6'b0, sq_q[idx_q], 28'b0};
		ge_c   = (rhs_c >= cand_c);
		qt_c   = qn_q | (15'd1 << b_q);
		rn_c   = {r_q[LenW-1:0], bit_q == top_q};
		pow2_c = (sh_q[LenW-2:0] == '0);
	end

	assign pop = (state_q == ST_IDLE) && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			strobe  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!qstat.empty) begin
						ent_q   <= head;
						idx_q   <= '0;
						len_q   <= '0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					sq_q[idx_q] <= sqr_c;
					len_q <= len_q + LenW'(sqr_c);
					if (idx_q == 2'd2) state_q <= ST_CHK;
					else idx_q <= idx_q + 1'b1;
				end
				ST_CHK: begin
					deg_q <= (len_q == '0);
					sh_q  <= len_q;
					k_q   <= 7'(LenW);
					if (len_q == '0) begin
						nm_q    <= '0;
						mant_q  <= '0;
						ex_q    <= '0;
						slot_q  <= SlotEdge0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sh_q[LenW-1]) begin
						ex_q  <= pow2_c ? 8'(k_q) - 8'sd2 : 8'(k_q) - 8'sd1;
						top_q <= pow2_c ? k_q + 7'd30 : k_q + 7'd31;
						idx_q <= '0;
						b_q   <= 4'd14;
						p_q   <= '0;
						qv_q  <= '0;
						qn_q  <= '0;
						state_q <= ST_NORM;
					end else begin
						sh_q <= sh_q << 1;
						k_q  <= k_q - 1'b1;
					end
				end
				ST_NORM: begin
					if (ge_c) begin
						p_q  <= cand_c;
						qv_q <= qv_q + (lw_c << b_q);
						qn_q <= qt_c;
					end
					if (b_q == '0) begin
						nm_q[2-idx_q] <= ent_q.cr[2-idx_q][CrossW-1]
							? -EdgeW'(ge_c ? qt_c : qn_q) : EdgeW'(ge_c ? qt_c : qn_q);
						b_q  <= 4'd14;
						p_q  <= '0;
						qv_q <= '0;
						qn_q <= '0;
						if (idx_q == 2'd2) begin
							r_q     <= '0;
							mant_q  <= '0;
							bit_q   <= top_q;
							state_q <= ST_DIV;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						b_q <= b_q - 1'b1;
					end
				end
				ST_DIV: begin
					if (rn_c >= (LenW+1)'(len_q)) begin
						r_q    <= rn_c - (LenW+1)'(len_q);
						mant_q <= {mant_q[30:0], 1'b1};
					end else begin
						r_q    <= rn_c;
						mant_q <= {mant_q[30:0], 1'b0};
					end
					if (bit_q == '0) begin
						slot_q  <= SlotEdge0;
						state_q <= ST_EMIT;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				ST_EMIT: begin
					strobe         <= 1'b1;
					slot           <= slot_q;
					last_result    <= (slot_q == SlotCentre);
					degenerate     <= deg_q;
					recip_exponent <= '0;
					unique case (slot_q)
						SlotEdge0: begin
							{vec_x, vec_y, vec_z} <= ent_q.e0;
							scalar_value <= ent_q.d00;
						end
						SlotEdge1: begin
							{vec_x, vec_y, vec_z} <= ent_q.e1;
							scalar_value <= ent_q.d11;
						end
						SlotNormal: begin
							{vec_x, vec_y, vec_z} <= nm_q;
							scalar_value <= ent_q.d01;
						end
						SlotCentre: begin
							{vec_x, vec_y, vec_z} <= ent_q.cen;
							scalar_value   <= DotW'(mant_q);
							recip_exponent <= ex_q;
						end
						default: ;
					endcase
					slot_q <= slot_q + 1'b1;
					if (slot_q == SlotCentre) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (last_result == (slot == SlotCentre)))
		else $error("last flag out of step with slot");
	a_slot_seq: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && slot != SlotCentre |=> strobe && slot == $past(slot) + 2'd1)
		else $error("result beats not consecutive");
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && degenerate && slot == SlotCentre |-> scalar_value == '0)
		else $error("degenerate triangle with nonzero mantissa");
	a_norm_mant: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !degenerate && slot == SlotCentre |-> scalar_value[31])
		else $error("mantissa not normalised");

endmodule

// ----- hw/rtl/triangle_setup.sv -----
// Triangle setup: edges, dot products, unit normal, centroid and reciprocal.
// From input beat to first result beat: front-end stages, queue, squares of the normal,
// leading-one scan of |n|^2, bit-serial normal loop, reciprocal division; a degenerate
// triangle goes from the squares straight to the four consecutive result beats.
// The back end pops the queue only when idle; the front end accepts new triangles while
// the queue and its own stages hold fewer than four. Reset clears control state.
module triangle_setup (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] ax,
	input  logic signed [15:0] ay,
	input  logic signed [15:0] az,
	input  logic signed [15:0] bx,
	input  logic signed [15:0] by_coord,
	input  logic signed [15:0] bz,
	input  logic signed [15:0] cx,
	input  logic signed [15:0] cy,
	input  logic signed [15:0] cz,
	output logic               strobe,
	output logic [1:0]         slot,
	output logic               last_result,
	output logic signed [16:0] vec_x,
	output logic signed [16:0] vec_y,
	output logic signed [16:0] vec_z,
	output logic signed [34:0] scalar_value,
	output logic signed [7:0]  recip_exponent,
	output logic               degenerate
);
	import ts_pkg::*;

	q_status_t qstat;
	logic      push, pop;
	entry_t    push_data, head;

	ts_front u_front (
		.clk, .arst_n, .start, .busy,
		.ax, .ay, .az, .bx, .by_coord, .bz, .cx, .cy, .cz,
		.qstat, .push, .push_data
	);

	ts_queue u_queue (
		.clk, .arst_n, .push, .push_data, .pop, .head, .qstat
	);

	ts_back u_back (
		.clk, .arst_n, .qstat, .head, .pop,
		.strobe, .slot, .last_result, .vec_x, .vec_y, .vec_z,
		.scalar_value, .recip_exponent, .degenerate
	);

endmodule
